@@ hw/rtl/segmented_sum_top3_tracker_defines.svh @@
// assertion macros for segmented_sum_top3_tracker.sv
`ifndef SEGMENTED_SUM_TOP3_TRACKER_DEFINES_SVH
`define SEGMENTED_SUM_TOP3_TRACKER_DEFINES_SVH

`ifndef NO_ASSERTIONS
// checked outside reset only
`define SST3_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);
// checked on every edge, reset included
`define SST3_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);
`else
`define SST3_ASSERT(lbl, prop, msg)
`define SST3_ASSERT_ALWAYS(lbl, prop, msg)
`endif

`endif

@@ hw/rtl/sst3_pkg.sv @@
package sst3_pkg;

  // fixed field widths
  localparam int unsigned CharWidth    = 8;
  localparam int unsigned LargestWidth = 32;
  localparam int unsigned TopSumWidth  = 34;
  localparam int unsigned DigitWidth   = 4;

  // character codes
  localparam logic [CharWidth-1:0] CharZero    = 8'h30;
  localparam logic [CharWidth-1:0] CharNine    = 8'h39;
  localparam logic [CharWidth-1:0] CharNewline = 8'h0A;

endpackage

@@ hw/rtl/sst3_if.sv @@
interface sst3_in_if import sst3_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [CharWidth-1:0] char_byte;
  logic                 end_of_input;

  modport source (output valid, output char_byte, output end_of_input, input ready);
  modport sink   (input valid, input char_byte, input end_of_input, output ready);
endinterface

interface sst3_out_if import sst3_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic [LargestWidth-1:0] largest_sum;
  logic [TopSumWidth-1:0]  top_three_sum;
  logic                    group_closed;

  modport source (output valid, output largest_sum, output top_three_sum,
                  output group_closed, input ready);
  modport sink   (input valid, input largest_sum, input top_three_sum,
                  input group_closed, output ready);
endinterface

@@ hw/rtl/segmented_sum_top3_tracker.sv @@
// path: an accepted input beat enters the input register, its result the result register
// throughput: one beat per cycle while out_o.ready drains results; the whole per-byte
//   update (multiply by ten, saturating add, three compares) is one combinational step
//   between the two registers
// reset: asynchronous, active low; clears line, group and top-three state and empties
//   both register stages
`include "segmented_sum_top3_tracker_defines.svh"

module segmented_sum_top3_tracker import sst3_pkg::*; #(
  parameter int unsigned SUM_WIDTH = 32,
  parameter int unsigned TOP_COUNT = 3
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  sst3_in_if.sink   in_i,
  sst3_out_if.source out_o
);

  localparam int unsigned SW = SUM_WIDTH;

  // ---------------------------------------------------------------------------
  // handshake: input register feeds the update, result register feeds out_o
  // ---------------------------------------------------------------------------
  logic                 in_valid_q;
  logic [CharWidth-1:0] in_char_q;
  logic                 in_eoi_q;
  logic                 out_valid_q;
  logic                 advance;

  // an item moves on when the result register is empty or being drained
  assign advance       = in_valid_q && (!out_valid_q || out_o.ready);
  assign in_i.ready    = !in_valid_q || advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_i.ready) begin
      in_valid_q <= in_i.valid;
    end
  end

  // input payload, no reset needed
  always_ff @(posedge clk_i) begin
    if (in_i.valid && in_i.ready) begin
      in_char_q <= in_i.char_byte;
      in_eoi_q  <= in_i.end_of_input;
    end
  end

  // ---------------------------------------------------------------------------
  // tracker state
  // ---------------------------------------------------------------------------
  logic [SW-1:0] line_value_q, line_value_d;
  logic          line_has_digit_q, line_has_digit_d;
  logic [SW-1:0] group_sum_q, group_sum_d;
  logic [SW-1:0] top_low_q, top_low_d;
  logic [SW-1:0] top_mid_q, top_mid_d;
  logic [SW-1:0] top_high_q, top_high_d;

  // ---------------------------------------------------------------------------
  // per-byte update
  // ---------------------------------------------------------------------------
  logic                  is_digit;
  logic                  is_newline;
  logic [DigitWidth-1:0] digit;
  logic [SW+3:0]         line_next;      // line_value * 10 + digit, with headroom
  logic [SW-1:0]         line_sat;
  logic [SW:0]           group_plus;     // group_sum + line_value, with carry
  logic [SW-1:0]         group_fin;      // group sum once the pending line is folded in
  logic                  close_grp;
  logic                  gt_low, gt_mid, gt_high;
  logic [SW+1:0]         three_sum;

  assign is_digit   = (in_char_q >= CharZero) && (in_char_q <= CharNine);
  assign is_newline = (in_char_q == CharNewline);
  assign digit      = DigitWidth'(in_char_q - CharZero);

  // times ten as shift-and-add; overflow shows in the top four bits
  assign line_next = ({4'b0000, line_value_q} << 3) + ({4'b0000, line_value_q} << 1)
                   + (SW+4)'(digit);
  assign line_sat  = (line_next[SW+3:SW] != 4'b0000) ? '1 : line_next[SW-1:0];

  // saturating add of the pending line into the group
  assign group_plus = {1'b0, group_sum_q} + {1'b0, line_value_q};
  always_comb begin
    if (!line_has_digit_q) begin
      group_fin = group_sum_q;
    end else if (group_plus[SW]) begin
      group_fin = '1;
    end else begin
      group_fin = group_plus[SW-1:0];
    end
  end

  // a blank line or end of input closes; a digit-less line only counts as blank
  assign close_grp = in_eoi_q || (is_newline && !line_has_digit_q);

  // strict compares, so a tie ranks below the entry already held
  assign gt_high = group_fin > top_high_q;
  assign gt_mid  = group_fin > top_mid_q;
  assign gt_low  = group_fin > top_low_q;

  always_comb begin
    line_value_d     = line_value_q;
    line_has_digit_d = line_has_digit_q;
    group_sum_d      = group_sum_q;
    top_low_d        = top_low_q;
    top_mid_d        = top_mid_q;
    top_high_d       = top_high_q;

    if (in_eoi_q || is_newline) begin
      // line ends either way
      line_value_d     = '0;
      line_has_digit_d = 1'b0;
      group_sum_d      = close_grp ? '0 : group_fin;
    end else if (is_digit) begin
      line_value_d     = line_sat;
      line_has_digit_d = 1'b1;
    end

    if (close_grp) begin
      // insert into the sorted set; unused low slots stay zero
      if (gt_high) begin
        top_high_d = group_fin;
        if (TOP_COUNT >= 2) top_mid_d = top_high_q;
        if (TOP_COUNT >= 3) top_low_d = top_mid_q;
      end else if (gt_mid && (TOP_COUNT >= 2)) begin
        top_mid_d = group_fin;
        if (TOP_COUNT >= 3) top_low_d = top_mid_q;
      end else if (gt_low && (TOP_COUNT >= 3)) begin
        top_low_d = group_fin;
      end
    end
  end

  assign three_sum = {2'b00, top_low_d} + {2'b00, top_mid_d} + {2'b00, top_high_d};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      line_value_q     <= '0;
      line_has_digit_q <= 1'b0;
      group_sum_q      <= '0;
      top_low_q        <= '0;
      top_mid_q        <= '0;
      top_high_q       <= '0;
    end else if (advance) begin
      line_value_q     <= line_value_d;
      line_has_digit_q <= line_has_digit_d;
      group_sum_q      <= group_sum_d;
      top_low_q        <= top_low_d;
      top_mid_q        <= top_mid_d;
      top_high_q       <= top_high_d;
    end
  end

  // ---------------------------------------------------------------------------
  // result register
  // ---------------------------------------------------------------------------
  logic [LargestWidth-1:0] largest_q;
  logic [TopSumWidth-1:0]  top_sum_q;
  logic                    closed_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= 1'b1;
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      // fields carry the low bits, zero-extended when the sums are narrower
      largest_q <= LargestWidth'(top_high_d);
      top_sum_q <= TopSumWidth'(three_sum);
      closed_q  <= close_grp;
    end
  end

  assign out_o.valid         = out_valid_q;
  assign out_o.largest_sum   = largest_q;
  assign out_o.top_three_sum = top_sum_q;
  assign out_o.group_closed  = closed_q;

  // ---------------------------------------------------------------------------
  // assertions
  // ---------------------------------------------------------------------------
  `SST3_ASSERT_ALWAYS(a_top_sorted, (top_low_q <= top_mid_q) && (top_mid_q <= top_high_q), "top set out of order")
  `SST3_ASSERT(a_closed_clears_group, (out_valid_q && closed_q) |-> (group_sum_q == '0), "group sum not cleared on close")
  `SST3_ASSERT(a_largest_tracks_top, out_valid_q |-> (largest_q == LargestWidth'(top_high_q)), "largest sum out of step with state")
  `SST3_ASSERT(a_ready_when_drained, !out_valid_q |-> in_i.ready, "input stalled with empty result register")
  `SST3_ASSERT_ALWAYS(a_empty_line_zero, !line_has_digit_q |-> (line_value_q == '0), "line value without digit")

endmodule

@@ dv/tb_segmented_sum_top3_tracker.sv @@
`timescale 1ns / 100ps

module tb_segmented_sum_top3_tracker;
  import sst3_pkg::*;

  // build under test: full-width sums, three kept entries
  localparam int unsigned SumWidth    = 32;
  localparam int unsigned KeepCount   = 3;
  localparam logic [SumWidth-1:0] SumMax = '1;

  // carriage return, the usual ignored byte
  localparam logic [CharWidth-1:0] CharReturn = 8'h0D;

  // stimulus sizing and run limits
  localparam int RandomBeats = 850;
  localparam int HoldCycles  = 120;
  localparam int CycleLimit  = 200_000;
  localparam int DrainCycles = 20;
  localparam int PrintCap    = 100;

  typedef struct packed {
    logic [CharWidth-1:0] ch;
    logic                 eoi;
    logic                 drain_first;  // sender waits for every result before this beat
  } text_beat_t;

  typedef struct packed {
    logic [LargestWidth-1:0] largest;
    logic [TopSumWidth-1:0]  top_sum;
    logic                    closed;
  } tally_t;

  logic clk_i = 1'b0;
  logic rst_ni;

  sst3_in_if  byte_if ();
  sst3_out_if tally_if ();

  segmented_sum_top3_tracker #(
    .SUM_WIDTH(SumWidth),
    .TOP_COUNT(KeepCount)
  ) u_top (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_i  (byte_if),
    .out_o (tally_if)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // stimulus store and expected tallies
  // ---------------------------------------------------------------------------
  text_beat_t pending[$];    // beats not yet offered to the block
  tally_t     tally_q[$];    // expected result beats, oldest first
  text_beat_t group_log[$];  // last well-formed group, replayed to force ties
  bit         logging    = 1'b0;
  bit         drain_next = 1'b0;
  int         err_cnt    = 0;
  int         beats_sent = 0;
  int         cycle_cnt  = 0;

  task automatic add_beat(input logic [CharWidth-1:0] ch, input logic eoi);
    text_beat_t b;
    b.ch          = ch;
    b.eoi         = eoi;
    b.drain_first = drain_next;
    drain_next    = 1'b0;
    pending.push_back(b);
    if (logging) group_log.push_back(b);
  endtask

  // ---------------------------------------------------------------------------
  // predictor: own copy of line, group and kept-sum state
  // ---------------------------------------------------------------------------
  logic [SumWidth-1:0] line_val;
  logic                line_has_digit;
  logic [SumWidth-1:0] grp_sum;
  logic [SumWidth-1:0] ranked [KeepCount];  // ascending: [0] lowest, [2] highest

  // fold a finished line into the group, saturating
  task automatic end_line();
    longint unsigned wide;
    if (line_has_digit) begin
      wide = 64'(grp_sum) + 64'(line_val);
      grp_sum = (wide > 64'(SumMax)) ? SumMax : wide[SumWidth-1:0];
    end
    line_val       = '0;
    line_has_digit = 1'b0;
  endtask

  // insert the group sum into the ranked set; strict compare so ties sit below
  task automatic close_group();
    logic [SumWidth-1:0] c;
    int                  i;
    c = grp_sum;
    if (c > ranked[0]) begin
      i = 0;
      while (i < KeepCount - 1 && c > ranked[i+1]) begin
        ranked[i] = ranked[i+1];
        i++;
      end
      ranked[i] = c;
    end
    grp_sum = '0;
  endtask

  task automatic fold_byte(input logic [CharWidth-1:0] ch, input logic eoi);
    longint unsigned wide;
    tally_t          t;
    logic            closed;
    closed = 1'b0;
    if (eoi) begin
      // pending line first, then the group; byte itself is don't-care
      end_line();
      close_group();
      closed = 1'b1;
    end else if (ch >= CharZero && ch <= CharNine) begin
      wide = 64'(line_val) * 64'd10 + 64'(ch - CharZero);
      line_val       = (wide > 64'(SumMax)) ? SumMax : wide[SumWidth-1:0];
      line_has_digit = 1'b1;
    end else if (ch == CharNewline) begin
      // a line with a digit (even a lone zero) is a number, otherwise it is blank
      if (line_has_digit) begin
        end_line();
      end else begin
        close_group();
        closed = 1'b1;
      end
    end
    // anything else, carriage return included, leaves the state alone
    t.largest = ranked[KeepCount-1];
    t.top_sum = TopSumWidth'(ranked[0]) + TopSumWidth'(ranked[1]) + TopSumWidth'(ranked[2]);
    t.closed  = closed;
    tally_q.push_back(t);
  endtask

  task automatic flag_mismatch(input string what, input logic [63:0] got,
                               input logic [63:0] want);
    if (err_cnt < PrintCap)
      $display("%0t mismatch on %s: got %0d, expected %0d", $realtime, what, got, want);
    err_cnt++;
  endtask

  // ---------------------------------------------------------------------------
  // driver: bursts of beats with random gaps, fed from the pending queue
  // ---------------------------------------------------------------------------
  int         burst_left;
  int         gap_left;
  text_beat_t cur;

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      byte_if.valid        <= 1'b0;
      byte_if.char_byte    <= '0;
      byte_if.end_of_input <= 1'b0;
      burst_left = 0;
      gap_left   = 0;
      line_val       = '0;
      line_has_digit = 1'b0;
      grp_sum        = '0;
      foreach (ranked[k]) ranked[k] = '0;
    end else begin
      // beat taken at this edge: predict its result
      if (byte_if.valid && byte_if.ready) begin
        fold_byte(byte_if.char_byte, byte_if.end_of_input);
        beats_sent <= beats_sent + 1;
      end
      // only move on once the current beat is gone (or none is offered)
      if (!byte_if.valid || byte_if.ready) begin
        if (gap_left != 0) begin
          gap_left--;
          byte_if.valid <= 1'b0;
        end else if (pending.size() != 0 &&
                     !(pending[0].drain_first && tally_q.size() != 0)) begin
          cur = pending.pop_front();
          byte_if.valid        <= 1'b1;
          byte_if.char_byte    <= cur.ch;
          byte_if.end_of_input <= cur.eoi;
          if (burst_left <= 1) begin
            // now and then a long burst with no idling at all
            burst_left = ($urandom_range(0, 5) == 0) ? 64 : $urandom_range(1, 16);
            gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
          end else begin
            burst_left--;
          end
        end else begin
          byte_if.valid <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // receiver: 16-bit ready pattern rerolled each lap, plus long hold-offs
  // ---------------------------------------------------------------------------
  int          hold_left;
  int          next_hold_at;
  logic [15:0] stall_pat;
  logic [3:0]  stall_pos;

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tally_if.ready <= 1'b0;
      hold_left    = 0;
      next_hold_at = 150;
      stall_pos    = '0;
      stall_pat    = '1;
    end else if (hold_left != 0) begin
      hold_left--;
      tally_if.ready <= 1'b0;
    end else if (beats_sent >= next_hold_at) begin
      // long hold-off: the sender keeps offering so the pipe fills and backs up
      hold_left    = HoldCycles;
      next_hold_at = next_hold_at + 350;
      tally_if.ready <= 1'b0;
    end else begin
      if (stall_pos == 0) begin
        case ($urandom_range(0, 3))
          0:       stall_pat = '1;                           // free flowing
          1:       stall_pat = 16'($urandom() & $urandom()); // mostly stalled
          default: stall_pat = 16'($urandom());
        endcase
      end
      tally_if.ready <= stall_pat[stall_pos];
      stall_pos = stall_pos + 1'b1;
    end
  end

  // ---------------------------------------------------------------------------
  // monitor: each result beat against the oldest expected tally
  // ---------------------------------------------------------------------------
  tally_t want;

  always @(posedge clk_i) begin
    if (rst_ni && tally_if.valid && tally_if.ready) begin
      if (tally_q.size() == 0) begin
        flag_mismatch("unexpected result beat", 64'(tally_if.largest_sum), 64'd0);
      end else begin
        want = tally_q.pop_front();
        if (tally_if.largest_sum !== want.largest)
          flag_mismatch("largest_sum", 64'(tally_if.largest_sum), 64'(want.largest));
        if (tally_if.top_three_sum !== want.top_sum)
          flag_mismatch("top_three_sum", 64'(tally_if.top_three_sum), 64'(want.top_sum));
        if (tally_if.group_closed !== want.closed)
          flag_mismatch("group_closed", 64'(tally_if.group_closed), 64'(want.closed));
      end
    end
  end

  // watchdog
  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CycleLimit) begin
      $display("tb_segmented_sum_top3_tracker: done, errors");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // stimulus build, reset and end of run
  // ---------------------------------------------------------------------------
  initial begin
    int                   n_lines;
    int                   n_digits;
    int                   roll;
    int                   target;
    bit                   mid_drained;
    logic [CharWidth-1:0] noise;

    byte_if.valid        = 1'b0;
    byte_if.char_byte    = '0;
    byte_if.end_of_input = 1'b0;
    tally_if.ready       = 1'b0;
    rst_ni               = 1'b0;
    mid_drained          = 1'b0;

    // end of input on a fresh stream: empty group, zero never kept
    add_beat(8'hFF, 1'b1);
    // a line holding just zero is a number, not a blank line
    add_beat(CharZero, 1'b0);
    add_beat(CharNewline, 1'b0);
    // blank line closes that group (sum zero)
    add_beat(CharNewline, 1'b0);
    // ignored bytes mid-line: carriage return and both byte extremes -> 42
    add_beat(CharZero + 8'd4, 1'b0);
    add_beat(CharReturn, 1'b0);
    add_beat(8'hFF, 1'b0);
    add_beat(8'h00, 1'b0);
    add_beat(CharZero + 8'd2, 1'b0);
    add_beat(CharNewline, 1'b0);
    // end of input with a line still open, byte alongside is ignored -> 42+7+3
    add_beat(CharZero + 8'd7, 1'b0);
    add_beat(CharNewline, 1'b0);
    add_beat(CharZero + 8'd3, 1'b0);
    add_beat(CharZero + 8'd5, 1'b1);
    // ten nines saturate the line value
    repeat (10) add_beat(CharNine, 1'b0);
    add_beat(CharNewline, 1'b0);
    add_beat(CharNewline, 1'b0);

    // sender waits for the pipe to empty before the random part
    drain_next = 1'b1;
    target     = pending.size() + RandomBeats;

    while (pending.size() < target) begin
      if (!mid_drained && pending.size() > target / 2) begin
        drain_next  = 1'b1;
        mid_drained = 1'b1;
      end
      roll = $urandom_range(0, 99);
      if (roll < 8) begin
        // raw noise, may include digits and newlines
        repeat ($urandom_range(1, 4)) add_beat(8'($urandom_range(0, 255)), 1'b0);
      end else if (roll < 18 && group_log.size() != 0) begin
        // same group again: equal sum, exercises the tie rule
        foreach (group_log[k]) add_beat(group_log[k].ch, group_log[k].eoi);
      end else begin
        group_log.delete();
        logging = 1'b1;
        n_lines = $urandom_range(1, 4);
        for (int ln = 0; ln < n_lines; ln++) begin
          roll = $urandom_range(0, 19);
          // mostly short numbers; now and then one long enough to saturate
          n_digits = (roll == 0) ? $urandom_range(10, 11) : $urandom_range(1, 4);
          for (int d = 0; d < n_digits; d++) begin
            add_beat((roll == 1) ? CharZero : CharZero + 8'($urandom_range(0, 9)), 1'b0);
            if ($urandom_range(0, 14) == 0) begin
              noise = 8'($urandom_range(0, 255));
              if ((noise >= CharZero && noise <= CharNine) || noise == CharNewline)
                noise = CharReturn;
              add_beat(noise, 1'b0);
            end
          end
          if (ln == n_lines - 1) begin
            roll = $urandom_range(0, 9);
            if (roll < 6) begin
              add_beat(CharNewline, 1'b0);
              add_beat(CharNewline, 1'b0);
            end else if (roll < 8) begin
              // end of input cuts the line short
              add_beat(8'($urandom_range(0, 255)), 1'b1);
            end else begin
              add_beat(CharNewline, 1'b0);
              add_beat(8'($urandom_range(0, 255)), 1'b1);
            end
          end else begin
            if ($urandom_range(0, 4) == 0) add_beat(CharReturn, 1'b0);
            add_beat(CharNewline, 1'b0);
          end
        end
        logging = 1'b0;
      end
    end

    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // everything offered, taken and answered
    while (pending.size() != 0 || byte_if.valid || tally_q.size() != 0) @(posedge clk_i);
    // catch any stray beats after the last expected one
    repeat (DrainCycles) @(posedge clk_i);

    if (err_cnt == 0) begin
      $display("tb_segmented_sum_top3_tracker: done, clean");
    end else begin
      $display("tb_segmented_sum_top3_tracker: done, errors");
    end
    $finish;
  end

endmodule
